@@ design/pip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Coordinate widths, request and result structs, and the per-edge class
// that the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;

    typedef struct packed {
        t_coord query_lon;
        t_coord query_lat;
        t_coord edge_start_lon;
        t_coord edge_start_lat;
        t_coord edge_end_lon;
        t_coord edge_end_lat;
        logic   last_edge;
    } t_in;

    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } t_out;

    // classified edge: what the back end must do with it
    typedef struct packed {
        logic bnd;   // vertex hit or exact hit on a straddling edge
        logic tgl;   // toggle crossing parity
        logic last;  // close the polygon and report
    } t_cls;

    // first front stage: differences and cheap flags
    typedef struct packed {
        t_diff dqx;
        t_diff dqy;
        t_diff dex;
        t_diff dy;
        logic  vhit;
        logic  straddle;
        logic  last;
    } t_s1;

    // second front stage: cross products
    typedef struct packed {
        t_prod p_l;
        t_prod p_r;
        logic  dy_neg;
        logic  vhit;
        logic  straddle;
        logic  last;
    } t_s2;

endpackage

@@ design/pip_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_front: edge classifier
// Two register stages (differences, then cross products) followed by the
// exact product compare; pushes one class per edge into the queue.
// ----------------------------------------------------------------------------
module pip_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pip_pkg::t_in  i_data,
    output logic          o_stall,
    input  logic          i_full,
    output logic          o_push,
    output pip_pkg::t_cls o_cls
);

    logic           w_en;
    logic           r_s1_valid;
    logic           r_s2_valid;
    pip_pkg::t_s1   r_s1;
    pip_pkg::t_s1   n_s1;
    pip_pkg::t_s2   r_s2;
    logic           w_eq;
    logic           w_lt_raw;
    logic           w_left;

    // whole front advances together; holds when the queue is full
    assign w_en    = !i_full;
    assign o_stall = i_full;

    always_comb begin
        n_s1.dqx = {i_data.query_lon[pip_pkg::COORD_WIDTH-1], i_data.query_lon}
                 - {i_data.edge_start_lon[pip_pkg::COORD_WIDTH-1], i_data.edge_start_lon};
        n_s1.dqy = {i_data.query_lat[pip_pkg::COORD_WIDTH-1], i_data.query_lat}
                 - {i_data.edge_start_lat[pip_pkg::COORD_WIDTH-1], i_data.edge_start_lat};
        n_s1.dex = {i_data.edge_end_lon[pip_pkg::COORD_WIDTH-1], i_data.edge_end_lon}
                 - {i_data.edge_start_lon[pip_pkg::COORD_WIDTH-1], i_data.edge_start_lon};
        n_s1.dy  = {i_data.edge_end_lat[pip_pkg::COORD_WIDTH-1], i_data.edge_end_lat}
                 - {i_data.edge_start_lat[pip_pkg::COORD_WIDTH-1], i_data.edge_start_lat};
        n_s1.vhit = ((i_data.edge_start_lon == i_data.query_lon) &&
                     (i_data.edge_start_lat == i_data.query_lat)) ||
                    ((i_data.edge_end_lon == i_data.query_lon) &&
                     (i_data.edge_end_lat == i_data.query_lat));
        n_s1.straddle = (i_data.edge_start_lat > i_data.query_lat) !=
                        (i_data.edge_end_lat > i_data.query_lat);
        n_s1.last = i_data.last_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1          <= n_s1;
            r_s2.p_l      <= pip_pkg::t_prod'(r_s1.dqx) * pip_pkg::t_prod'(r_s1.dy);
            r_s2.p_r      <= pip_pkg::t_prod'(r_s1.dex) * pip_pkg::t_prod'(r_s1.dqy);
            r_s2.dy_neg   <= r_s1.dy[pip_pkg::DIFF_W-1];
            r_s2.vhit     <= r_s1.vhit;
            r_s2.straddle <= r_s1.straddle;
            r_s2.last     <= r_s1.last;
        end
    end

    // point left of crossing: p_l < p_r for rising edges, reversed for falling
    assign w_eq     = (r_s2.p_l == r_s2.p_r);
    assign w_lt_raw = (r_s2.p_l < r_s2.p_r);
    assign w_left   = r_s2.dy_neg ? (!w_eq && !w_lt_raw) : w_lt_raw;

    assign o_push     = r_s2_valid && w_en;
    assign o_cls.bnd  = r_s2.vhit || (r_s2.straddle && w_eq);
    assign o_cls.tgl  = r_s2.straddle && w_left;
    assign o_cls.last = r_s2.last;

endmodule

@@ design/pip_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_fifo: class queue
// Small register queue between the classifier and the parity tracker.
// ----------------------------------------------------------------------------
module pip_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pip_pkg::t_cls i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pip_pkg::t_cls o_data
);

    pip_pkg::t_cls                r_mem [pip_pkg::QUEUE_DEPTH];
    logic [pip_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [pip_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [pip_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == pip_pkg::QCNT_W'(pip_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/pip_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_back: parity tracker
// Folds each edge class into the parity and boundary flags and registers
// the result on the last edge of a polygon.
// ----------------------------------------------------------------------------
module pip_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pip_pkg::t_cls i_cls,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output pip_pkg::t_out o_data
);

    logic          r_par;
    logic          r_bnd;
    logic          r_out_valid;
    pip_pkg::t_out r_out;
    logic          n_par;
    logic          n_bnd;

    assign o_pop = i_valid && (!r_out_valid || !i_stall);
    assign n_par = r_par ^ i_cls.tgl;
    assign n_bnd = r_bnd | i_cls.bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par       <= 1'b0;
            r_bnd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_par <= i_cls.last ? 1'b0 : n_par;
                r_bnd <= i_cls.last ? 1'b0 : n_bnd;
            end
            if (o_pop && i_cls.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out.inside_res  <= n_bnd | n_par;
            r_out.on_boundary <= n_bnd;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ design/point_in_polygon_test_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_top: ray-casting point-in-polygon test
// Streams polygon edges with the query point and reports inside / on-boundary
// once per polygon, on the edge carrying the last-edge mark.
// ----------------------------------------------------------------------------
// Feed one request per polygon edge: both end vertices, the query point and
// the last-edge mark. The block takes one edge every clock cycle while the
// queue is not full. Each edge passes a three-step classifier (coordinate
// differences, two signed 33x33 cross products, an exact 66-bit compare),
// lands in a four-entry queue, and is folded into a crossing parity and a
// boundary flag by the back end. A result is produced only for the last edge,
// after the difference and product registers, the queue and the result
// register; the queue decouples input from output so the input stalls only
// when the queue is full. After the result the internal state is clear and
// the next polygon can follow at once. A point on a vertex, or exactly on a
// straddling edge, reports on_boundary and inside_res both set.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // edge requests
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pip_pkg::t_in  i_in_data,
    // results
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pip_pkg::t_out o_out_data
);

    // classifier to queue
    logic          w_push;
    pip_pkg::t_cls w_push_cls;
    logic          w_full;
    // queue to parity tracker
    logic          w_q_valid;
    pip_pkg::t_cls w_q_cls;
    logic          w_pop;

    // front end: computes differences, cross products and the edge class
    pip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cls   (w_push_cls)
    );

    // queue lets the classifier run ahead while a result waits downstream
    pip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cls),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cls)
    );

    // back end: parity / boundary accumulation and result register
    pip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cls   (w_q_cls),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // a boundary hit always reports as inside
    a_bnd_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.on_boundary || o_out_data.inside_res))
        else $error("on_boundary without inside_res");

    // the back end never retires a last edge over a result still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_q_cls.last) |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // nothing is pushed into a full queue, and nothing popped from an empty one
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full) && !(w_pop && !w_q_valid))
        else $error("queue overflow or underflow");
`endif

endmodule

@@ bench/point_in_polygon_test_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_top_tb: self-checking bench for the ray-casting test
// Streams polygon edges into the block and folds each accepted edge into a
// local crossing-parity / boundary predictor. Every reported verdict is
// compared with the oldest pending one. Directed shapes come first. Then come
// a back-pressure fill, a drain-and-resume phase and a long run of random
// polygons. Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top_tb;

    localparam int              WIDE_W         = 2 * pip_pkg::COORD_WIDTH + 6;
    localparam int              RESET_CYCLES   = 10;
    localparam int              HOLD_CYCLES    = 200;
    localparam int              TAIL_CYCLES    = 24;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              TOTAL_EDGES    = 1850;
    localparam int              MAX_VERTS      = 16;
    localparam pip_pkg::t_coord DEG            = 32'sd8388608;   // one degree, 2^23
    localparam pip_pkg::t_coord COORD_MAX      = 32'sh7fffffff;
    localparam pip_pkg::t_coord COORD_MIN      = 32'sh80000000;

    typedef logic signed [WIDE_W-1:0] t_wide;

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          in_valid  = 1'b0;
    pip_pkg::t_in  in_req    = '0;
    logic          out_stall = 1'b0;
    logic          in_stall;
    logic          out_valid;
    pip_pkg::t_out out_res;

    // predictor state, cleared on every closing edge
    bit            pred_odd     = 1'b0;
    bit            pred_on_edge = 1'b0;
    pip_pkg::t_out pending_verdicts[$];

    int    mismatches   = 0;
    int    edges_sent   = 0;
    int    quiet_cycles = 0;
    bit    calm         = 1'b0;  // no gaps and no stalls on either side
    bit    no_send_gap  = 1'b0;  // sender back to back
    bit    hold_req     = 1'b0;  // ask the result sink for a long hold-off

    point_in_polygon_test_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: one edge folded into parity / boundary state. Arithmetic
    // is carried wide enough that the cross products are exact.
    // ------------------------------------------------------------------
    function automatic bit fold_edge(input pip_pkg::t_in e, output pip_pkg::t_out verdict);
        t_wide qx, qy, sx, sy, ex, ey, dy, ady, lhs, rhs;
        qx = t_wide'(e.query_lon);
        qy = t_wide'(e.query_lat);
        sx = t_wide'(e.edge_start_lon);
        sy = t_wide'(e.edge_start_lat);
        ex = t_wide'(e.edge_end_lon);
        ey = t_wide'(e.edge_end_lat);
        verdict = '0;
        if ((sx == qx && sy == qy) || (ex == qx && ey == qy))
            pred_on_edge = 1'b1;
        if ((sy > qy) != (ey > qy)) begin
            // left of crossing <=> (qx-sx)*|dy| < (ex-sx)*(qy-sy)*sign(dy)
            dy  = ey - sy;
            ady = (dy < 0) ? -dy : dy;
            lhs = (qx - sx) * ady;
            rhs = (ex - sx) * (qy - sy);
            if (dy < 0)
                rhs = -rhs;
            if (lhs == rhs)
                pred_on_edge = 1'b1;
            else if (lhs < rhs)
                pred_odd = ~pred_odd;
        end
        if (!e.last_edge)
            return 1'b0;
        verdict.inside_res  = pred_on_edge | pred_odd;
        verdict.on_boundary = pred_on_edge;
        pred_odd     = 1'b0;
        pred_on_edge = 1'b0;
        return 1'b1;
    endfunction

    function automatic pip_pkg::t_in mk_edge(pip_pkg::t_coord qx, pip_pkg::t_coord qy,
                                             pip_pkg::t_coord sx, pip_pkg::t_coord sy,
                                             pip_pkg::t_coord ex, pip_pkg::t_coord ey,
                                             bit last);
        pip_pkg::t_in e;
        e.query_lon      = qx;
        e.query_lat      = qy;
        e.edge_start_lon = sx;
        e.edge_start_lat = sy;
        e.edge_end_lon   = ex;
        e.edge_end_lat   = ey;
        e.last_edge      = last;
        return e;
    endfunction

    // mostly short runs, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int send_gap();
        if (calm || no_send_gap)
            return 0;
        if ($urandom_range(0, 99) < 55)
            return 0;
        return gap_len();
    endfunction

    // grid points at a per-polygon scale hit vertices and edges exactly
    function automatic pip_pkg::t_coord rand_coord(int scale);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return pip_pkg::t_coord'((int'($urandom_range(0, 16)) - 8) <<< scale);
        if (r < 95)
            return pip_pkg::t_coord'(longint'($urandom_range(0, 32'd3019898880))
                                     - 64'sd1509949440);
        return pip_pkg::t_coord'($urandom());
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Sender: one edge request, held until accepted, then predicted.
    // Always returns on the accepting clock edge.
    // ------------------------------------------------------------------
    task automatic send_edge(input pip_pkg::t_in e);
        int            gap;
        pip_pkg::t_out verdict;
        gap = send_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= e;
        @(posedge i_clk);
        while (in_stall !== 1'b0)
            @(posedge i_clk);
        if (fold_edge(e, verdict))
            pending_verdicts = {pending_verdicts, verdict};
        edges_sent++;
    endtask

    // drop valid and wait for every pending verdict
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_square(input pip_pkg::t_coord qx, input pip_pkg::t_coord qy);
        send_edge(mk_edge(qx, qy,  0,      0,      10*DEG, 0,      1'b0));
        send_edge(mk_edge(qx, qy,  10*DEG, 0,      10*DEG, 10*DEG, 1'b0));
        send_edge(mk_edge(qx, qy,  10*DEG, 10*DEG, 0,      10*DEG, 1'b0));
        send_edge(mk_edge(qx, qy,  0,      10*DEG, 0,      0,      1'b1));
    endtask

    // closed ring, open chain, or noise with moving query and stray last marks
    task automatic send_random_polygon();
        pip_pkg::t_coord vx[MAX_VERTS];
        pip_pkg::t_coord vy[MAX_VERTS];
        pip_pkg::t_coord qx, qy, ex, ey;
        longint          mx, my;
        int              kind, n, scale, i, j, r;
        pip_pkg::t_in    e;
        kind  = $urandom_range(0, 99);
        r     = $urandom_range(0, 99);
        n     = (r < 10) ? $urandom_range(1, 2) : (r < 90) ? $urandom_range(3, 8)
                                                          : $urandom_range(9, MAX_VERTS);
        scale = $urandom_range(0, 26);
        for (i = 0; i < n; i++) begin
            vx[i] = rand_coord(scale);
            vy[i] = rand_coord(scale);
        end
        r = $urandom_range(0, 99);
        j = $urandom_range(0, n - 1);
        if (r < 40) begin
            qx = pip_pkg::t_coord'((int'($urandom_range(0, 16)) - 8) <<< scale);
            qy = pip_pkg::t_coord'((int'($urandom_range(0, 16)) - 8) <<< scale);
        end else if (r < 55) begin
            qx = vx[j];
            qy = vy[j];
        end else if (r < 70) begin
            // edge midpoint when it lands on the grid, else the vertex
            mx = longint'(vx[j]) + longint'(vx[(j + 1) % n]);
            my = longint'(vy[j]) + longint'(vy[(j + 1) % n]);
            qx = (mx % 2 == 0) ? pip_pkg::t_coord'(mx / 2) : vx[j];
            qy = (my % 2 == 0) ? pip_pkg::t_coord'(my / 2) : vy[j];
        end else if (r < 85) begin
            qx = rand_coord(scale);
            qy = rand_coord(scale);
        end else begin
            qx = pip_pkg::t_coord'($urandom());
            qy = pip_pkg::t_coord'($urandom());
        end
        for (i = 0; i < n; i++) begin
            ex = vx[(i + 1) % n];
            ey = vy[(i + 1) % n];
            if (kind >= 70 && kind < 85) begin
                ex = rand_coord(scale);
                ey = rand_coord(scale);
            end
            e = mk_edge(qx, qy, vx[i], vy[i], ex, ey, i == n - 1);
            if (kind >= 85) begin
                if ($urandom_range(0, 2) == 0) begin
                    e.query_lon = pip_pkg::t_coord'($urandom());
                    e.query_lat = pip_pkg::t_coord'($urandom());
                end
                if ($urandom_range(0, 3) == 0)
                    e.last_edge = 1'b1;
            end
            send_edge(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_square(5*DEG, 5*DEG);      // inside
        send_square(15*DEG, 5*DEG);     // outside
        send_square(10*DEG, 10*DEG);    // on a vertex; no edge straddles the query
        send_square(10*DEG, 5*DEG);     // exactly on a vertical edge
        // exactly on a slanted edge
        send_edge(mk_edge(4*DEG, 2*DEG, 0,     0,     8*DEG, 4*DEG, 1'b0));
        send_edge(mk_edge(4*DEG, 2*DEG, 8*DEG, 4*DEG, 0,     8*DEG, 1'b0));
        send_edge(mk_edge(4*DEG, 2*DEG, 0,     8*DEG, 0,     0,     1'b1));
        // single-edge polygons at the two's complement extremes
        send_edge(mk_edge(COORD_MAX, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1));
        send_edge(mk_edge(COORD_MIN, COORD_MAX - 1, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, 1'b1));
        // query point moves mid-polygon, vertices at the range limits
        send_edge(mk_edge(0,       0,      -180*DEG, -90*DEG, 180*DEG, -90*DEG, 1'b0));
        send_edge(mk_edge(-179*DEG, 89*DEG, 180*DEG, -90*DEG, 0,       180*DEG, 1'b0));
        send_edge(mk_edge(179*DEG, -89*DEG, 0,       180*DEG, -180*DEG, -90*DEG, 1'b1));
    endtask

    // result sink holds off while the sender keeps the input busy
    task automatic test_backpressure();
        int start;
        start       = edges_sent;
        no_send_gap = 1'b1;
        hold_req    = 1'b1;
        while (edges_sent - start < 40)
            send_random_polygon();
        no_send_gap = 1'b0;
    endtask

    // sender idles until every verdict is back, several times over
    task automatic test_drain_resume();
        repeat (6) begin
            send_random_polygon();
            wait_drained();
        end
    endtask

    task automatic test_random_polygons();
        while (edges_sent < TOTAL_EDGES) begin
            if ($urandom_range(0, 19) == 0)
                calm = ~calm;
            send_random_polygon();
        end
        calm = 1'b0;
    endtask

    initial begin : main_seq
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_drain_resume();
        test_random_polygons();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result sink: random stall runs, or one long hold when asked
    initial begin : result_sink
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (calm) begin
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 65) begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                out_stall <= 1'b1;
                n = gap_len();
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // verdict checker
    always @(posedge i_clk) begin
        pip_pkg::t_out want;
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("verdict with none pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (out_res.inside_res !== want.inside_res)
                    report_mismatch($sformatf("inside_res: want %0b got %0b",
                                              want.inside_res, out_res.inside_res));
                if (out_res.on_boundary !== want.on_boundary)
                    report_mismatch($sformatf("on_boundary: want %0b got %0b",
                                              want.on_boundary, out_res.on_boundary));
            end
        end
    end

    // watchdog: too long without any request or verdict moving
    always @(posedge i_clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
design/pip_pkg.sv
design/pip_front.sv
design/pip_fifo.sv
design/pip_back.sv
design/point_in_polygon_test_top.sv
bench/point_in_polygon_test_top_tb.sv
